// File: rtl/core/swmf_pkg.sv
// shared types and constants for the sliding window label mode filter
`default_nettype none

package swmf_pkg;

    // default sizes
    localparam int SWMF_MAX_WINDOW = 32;
    localparam int SWMF_LABEL_BITS = 16;

    // configuration port
    localparam int SWMF_CFG_W     = 6;
    localparam int SWMF_CFG_IDX_W = 1;

    // register reset values
    localparam logic [SWMF_CFG_W-1:0] SWMF_MIN_COUNT_RST     = SWMF_CFG_W'(1);
    localparam logic [SWMF_CFG_W-1:0] SWMF_WINDOW_LENGTH_RST = SWMF_CFG_W'(5);

    // register indexes
    typedef enum logic [SWMF_CFG_IDX_W-1:0] {
        REG_MIN_COUNT     = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FINISH
    } seq_state_t;

    // commands from the sequencer to the cell chain
    typedef struct packed {
        logic clear;   // wipe labels and counts
        logic insert;  // drop oldest, append new label at the tail
        logic shift;   // rotate one scan position toward the head
    } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/swmf_if.sv
// stream interfaces for the label input and filtered output channels
`default_nettype none

interface label_in_if
    import swmf_pkg::*;
#(
    parameter int LABEL_BITS = SWMF_LABEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] class_label;

    modport source (output valid, output class_label, input ready);
    modport sink   (input valid, input class_label, output ready);
endinterface

interface label_out_if
    import swmf_pkg::*;
#(
    parameter int LABEL_BITS = SWMF_LABEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] filtered_label;

    modport source (output valid, output filtered_label, input ready);
    modport sink   (input valid, input filtered_label, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swmf_cell.sv
// one window slot: a label and its running match count, passed toward the head
`default_nettype none

module swmf_cell
    import swmf_pkg::*;
#(
    parameter int LABEL_BITS = SWMF_LABEL_BITS,
    parameter int CNT_W      = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chain_ctrl_t           ctrl,
    input  logic                  is_tail,
    input  logic [LABEL_BITS-1:0] tail_label,
    input  logic [LABEL_BITS-1:0] head_label,
    input  logic [LABEL_BITS-1:0] nb_label,
    input  logic [CNT_W-1:0]      nb_count,
    output logic [LABEL_BITS-1:0] label,
    output logic [CNT_W-1:0]      count_fwd
);

    logic [LABEL_BITS-1:0] label_reg, label_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  match;

    // compare against the label leaving the head this cycle
    assign match     = (label_reg == head_label);
    assign count_fwd = count_reg + CNT_W'(match);
    assign label     = label_reg;

    // next slot contents
    always_comb
    begin
        label_next = label_reg;
        count_next = count_reg;
        priority if (ctrl.clear)
        begin
            label_next = '0;
            count_next = '0;
        end
        else if (ctrl.insert)
        begin
            label_next = is_tail ? tail_label : nb_label;
            count_next = '0;
        end
        else if (ctrl.shift)
        begin
            label_next = is_tail ? tail_label : nb_label;
            count_next = is_tail ? '0 : nb_count;
        end
        else
        begin
            // hold the slot
            label_next = label_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            label_reg <= label_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swmf_chain.sv
// row of window cells; cell 0 is the oldest entry, the tail sits at length - 1
`default_nettype none

module swmf_chain
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = SWMF_MAX_WINDOW,
    parameter int LABEL_BITS = SWMF_LABEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chain_ctrl_t           ctrl,
    input  logic [LABEL_BITS-1:0] new_label,
    input  logic [(($clog2(MAX_WINDOW+1) > SWMF_CFG_W) ?
                   $clog2(MAX_WINDOW+1) : SWMF_CFG_W) - 1:0] len_m1,
    output logic [LABEL_BITS-1:0] head_label,
    output logic [$clog2(MAX_WINDOW+1)-1:0] head_count
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > SWMF_CFG_W) ? CNT_W : SWMF_CFG_W;

    logic [LABEL_BITS-1:0] cell_label [MAX_WINDOW+1];
    logic [CNT_W-1:0]      cell_count [MAX_WINDOW+1];
    logic [LABEL_BITS-1:0] tail_label;

    // tail takes the new beat on insert, the head label while rotating
    assign tail_label = ctrl.insert ? new_label : cell_label[0];

    // nothing beyond the last cell
    assign cell_label[MAX_WINDOW] = '0;
    assign cell_count[MAX_WINDOW] = '0;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        logic is_tail;
        assign is_tail = (len_m1 == LEN_W'(k));

        swmf_cell #(
            .LABEL_BITS (LABEL_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .is_tail    (is_tail),
            .tail_label (tail_label),
            .head_label (cell_label[0]),
            .nb_label   (cell_label[k+1]),
            .nb_count   (cell_count[k+1]),
            .label      (cell_label[k]),
            .count_fwd  (cell_count[k])
        );
    end

    // head count already includes the head itself
    assign head_label = cell_label[0];
    assign head_count = cell_count[0];

endmodule

`default_nettype wire

// File: rtl/core/swmf_seq.sv
// scan sequencer, best label tracking and output register
`default_nettype none

module swmf_seq
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = SWMF_MAX_WINDOW,
    parameter int LABEL_BITS = SWMF_LABEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LABEL_BITS-1:0] out_label,
    input  logic                  cfg_clear,
    input  logic [(($clog2(MAX_WINDOW+1) > SWMF_CFG_W) ?
                   $clog2(MAX_WINDOW+1) : SWMF_CFG_W) - 1:0] len_m1,
    input  logic [SWMF_CFG_W-1:0] min_count,
    input  logic [LABEL_BITS-1:0] head_label,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] head_count,
    output chain_ctrl_t           ctrl
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > SWMF_CFG_W) ? CNT_W : SWMF_CFG_W;

    seq_state_t            state_reg, state_next;
    logic [LEN_W-1:0]      step_reg, step_next;
    logic [LABEL_BITS-1:0] best_label_reg, best_label_next;
    logic [CNT_W-1:0]      best_count_reg, best_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LABEL_BITS-1:0] out_label_reg, out_label_next;
    logic                  in_fire;
    logic                  scan_last;
    logic                  out_free;
    logic                  load;
    logic                  meets_min;

    assign in_fire   = in_valid && in_ready;
    assign scan_last = (step_reg == len_m1);
    assign out_free  = !out_valid_reg || out_ready;
    assign meets_min = (LEN_W'(best_count_reg) >= LEN_W'(min_count));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready    = 1'b0;
        load        = 1'b0;
        ctrl.clear  = cfg_clear;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.insert = in_valid;
            end
            SEQ_SCAN:
            begin
                ctrl.shift = 1'b1;
            end
            SEQ_FINISH:
            begin
                load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // scan position and best candidate
    always_comb
    begin
        step_next       = step_reg;
        best_label_next = best_label_reg;
        best_count_next = best_count_reg;
        if (in_fire)
        begin
            step_next = '0;
        end
        else if (state_reg == SEQ_SCAN)
        begin
            step_next = step_reg + LEN_W'(1);
            if (step_reg == '0)
            begin
                best_label_next = head_label;
                best_count_next = CNT_W'(1);
            end
            else if (head_count > best_count_reg && head_label != '0)
            begin
                best_label_next = head_label;
                best_count_next = head_count;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_label_next = out_label_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_label_next = meets_min ? best_label_reg : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_label_reg <= best_label_next;
        best_count_reg <= best_count_next;
        out_label_reg  <= out_label_next;
    end

    assign out_valid = out_valid_reg;
    assign out_label = out_label_reg;

`ifndef SYNTHESIS
    // an accepted beat starts the scan at the oldest entry
    a_fire_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == SEQ_SCAN) && (step_reg == '0))
        else $error("scan did not start after accepted beat");

    // the scan ends after the newest entry
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_SCAN) && scan_last |=> (state_reg == SEQ_FINISH))
        else $error("scan did not end at window length");

    // a finished result lands in a free output register
    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_FINISH) && !out_valid_reg |=> out_valid_reg
            && (state_reg == SEQ_IDLE))
        else $error("finished result not loaded");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_label_mode_filter.sv
// top level of the sliding window label mode filter
//
//  channel    dir  handshake      payload
//  label_in   in   valid/ready    class_label    [LABEL_BITS]
//  label_out  out  valid/ready    filtered_label [LABEL_BITS]
//  cfg        in   cfg_write_en   cfg_index, cfg_data [6]
//
//  a beat is handled in steps: the new label is shifted in, the window rotates
//  past the head counter entry by entry, and the result is loaded into the output
//  register once it is free; a new beat is taken only after that load
//  rst_n clears the window, the sequencer and the configuration registers to their defaults
//  a configuration write clears the window as well
//  a full output register holds the finished result until label_out.ready
`default_nettype none

module sliding_window_label_mode_filter
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = SWMF_MAX_WINDOW,
    parameter int LABEL_BITS = SWMF_LABEL_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    label_in_if.sink                  label_in,
    label_out_if.source               label_out,
    input  logic                      cfg_write_en,
    input  logic [SWMF_CFG_IDX_W-1:0] cfg_index,
    input  logic [SWMF_CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > SWMF_CFG_W) ? CNT_W : SWMF_CFG_W;

    logic [SWMF_CFG_W-1:0] min_count_reg, min_count_next;
    logic [SWMF_CFG_W-1:0] window_length_reg, window_length_next;
    logic                  cfg_clear;
    logic [LEN_W-1:0]      wl_ext;
    logic [LEN_W-1:0]      len_m1;
    chain_ctrl_t           ctrl;
    logic [LABEL_BITS-1:0] head_label;
    logic [CNT_W-1:0]      head_count;

    // register writes; any write clears the window
    always_comb
    begin
        min_count_next     = min_count_reg;
        window_length_next = window_length_reg;
        cfg_clear          = 1'b0;
        if (cfg_write_en)
        begin
            cfg_clear = 1'b1;
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_COUNT:     min_count_next     = cfg_data;
                REG_WINDOW_LENGTH: window_length_next = cfg_data;
                default:           cfg_clear          = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg     <= SWMF_MIN_COUNT_RST;
            window_length_reg <= SWMF_WINDOW_LENGTH_RST;
        end
        else
        begin
            min_count_reg     <= min_count_next;
            window_length_reg <= window_length_next;
        end
    end

    // window length clamped to 1..MAX_WINDOW, kept as length - 1
    assign wl_ext = LEN_W'(window_length_reg);
    always_comb
    begin
        priority if (wl_ext == '0)
        begin
            len_m1 = '0;
        end
        else if (wl_ext > LEN_W'(MAX_WINDOW))
        begin
            len_m1 = LEN_W'(MAX_WINDOW - 1);
        end
        else
        begin
            len_m1 = wl_ext - LEN_W'(1);
        end
    end

    swmf_chain #(
        .MAX_WINDOW (MAX_WINDOW),
        .LABEL_BITS (LABEL_BITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_label  (label_in.class_label),
        .len_m1     (len_m1),
        .head_label (head_label),
        .head_count (head_count)
    );

    swmf_seq #(
        .MAX_WINDOW (MAX_WINDOW),
        .LABEL_BITS (LABEL_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (label_in.valid),
        .in_ready   (label_in.ready),
        .out_valid  (label_out.valid),
        .out_ready  (label_out.ready),
        .out_label  (label_out.filtered_label),
        .cfg_clear  (cfg_clear),
        .len_m1     (len_m1),
        .min_count  (min_count_reg),
        .head_label (head_label),
        .head_count (head_count),
        .ctrl       (ctrl)
    );

endmodule

`default_nettype wire

// File: tb/sv/sliding_window_label_mode_filter_tb.sv
// testbench for the label mode filter: directed table, then random phases checked by a predictor
module sliding_window_label_mode_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    localparam int LBL_W         = SWMF_LABEL_BITS;
    localparam int WIN_MAX       = SWMF_MAX_WINDOW;
    localparam int TARGET_LABELS = 1850;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = WIN_MAX + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int NUM_DIR_ROWS  = 36;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_EVERY_THIRD,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          reg_idx;
        logic [LBL_W-1:0]  value;
        logic              typed;
        logic [LBL_W-1:0]  result;
    } stim_row_t;

    // directed rows: register writes and labels, fixed results where obvious
    stim_row_t dir_rows [NUM_DIR_ROWS] = '{
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0000, 1'b1, 16'h0000}, // window of zeros after reset
        '{ROW_ITEM, REG_MIN_COUNT,     16'hFFFF, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'hFFFF, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0001, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0001, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0001, 1'b0, 16'h0000},
        '{ROW_CFG,  REG_MIN_COUNT,     16'd3,    1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h8000, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h8000, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h8000, 1'b0, 16'h0000},
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd0,    1'b0, 16'h0000}, // zero length acts as one
        '{ROW_ITEM, REG_MIN_COUNT,     16'h5555, 1'b1, 16'h0000},
        '{ROW_CFG,  REG_MIN_COUNT,     16'd0,    1'b0, 16'h0000}, // any count passes
        '{ROW_ITEM, REG_MIN_COUNT,     16'hAAAA, 1'b1, 16'hAAAA},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0000, 1'b1, 16'h0000},
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd63,   1'b0, 16'h0000}, // clamps to full window
        '{ROW_CFG,  REG_MIN_COUNT,     16'd63,   1'b0, 16'h0000}, // unreachable count
        '{ROW_ITEM, REG_MIN_COUNT,     16'h1234, 1'b1, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'hFFFF, 1'b1, 16'h0000},
        '{ROW_CFG,  REG_MIN_COUNT,     16'd1,    1'b0, 16'h0000},
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd32,   1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h00FF, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'hFF00, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h00FF, 1'b0, 16'h0000},
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd2,    1'b0, 16'h0000},
        '{ROW_CFG,  REG_MIN_COUNT,     16'd2,    1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0007, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0007, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0000, 1'b0, 16'h0000},
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd1,    1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0001, 1'b1, 16'h0000}, // count above window length
        '{ROW_CFG,  REG_WINDOW_LENGTH, 16'd3,    1'b0, 16'h0000},
        '{ROW_CFG,  REG_MIN_COUNT,     16'd1,    1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0002, 1'b0, 16'h0000}, // zero oldest entry
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0000, 1'b0, 16'h0000},
        '{ROW_ITEM, REG_MIN_COUNT,     16'h0002, 1'b0, 16'h0000}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [SWMF_CFG_IDX_W-1:0] cfg_index;
    logic [SWMF_CFG_W-1:0]     cfg_data;

    label_in_if  #(.LABEL_BITS(LBL_W)) lin ();
    label_out_if #(.LABEL_BITS(LBL_W)) lout ();

    sliding_window_label_mode_filter #(
        .MAX_WINDOW (WIN_MAX),
        .LABEL_BITS (LBL_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .label_in     (lin),
        .label_out    (lout),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [LBL_W-1:0]      hist_q [WIN_MAX];
    int unsigned           head_q;
    logic [SWMF_CFG_W-1:0] min_count_q;
    logic [SWMF_CFG_W-1:0] win_len_q;

    logic [LBL_W-1:0] pending_labels [$];
    logic [LBL_W-1:0] expected_label;

    int  error_count;
    int  labels_sent;
    int  labels_checked;
    int  cfg_count;
    int  hold_count;
    int  cycle_count;
    int  burst_left;
    bit  steady;
    bit  hold_req;

    // receiver state
    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_hold_left;
    int       rx_tick;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sliding_window_label_mode_filter_tb: errors");
            $finish;
        end
    end

    function automatic int unsigned active_length();
        int unsigned n;
        n = win_len_q;
        if (n < 1)
            n = 1;
        if (n > WIN_MAX)
            n = WIN_MAX;
        return n;
    endfunction

    function automatic void wipe_history();
        foreach (hist_q[i])
            hist_q[i] = '0;
        head_q = 0;
    endfunction

    function automatic void predict_config(cfg_reg_t idx, logic [SWMF_CFG_W-1:0] v);
        case (idx)
            REG_MIN_COUNT:     min_count_q = v;
            REG_WINDOW_LENGTH: win_len_q   = v;
            default:           ;
        endcase
        wipe_history();
    endfunction

    // insert the label, then scan oldest to newest with running counts
    function automatic logic [LBL_W-1:0] predict_mode(logic [LBL_W-1:0] lbl);
        int unsigned      len;
        int unsigned      cnt;
        int unsigned      best_cnt;
        logic [LBL_W-1:0] best;
        logic [LBL_W-1:0] cur;
        len = active_length();
        if (head_q >= len)
            head_q = 0;
        hist_q[head_q] = lbl;
        head_q = (head_q + 1 >= len) ? 0 : head_q + 1;
        best     = hist_q[head_q];
        best_cnt = 1;
        for (int unsigned i = 1; i < len; i++)
        begin
            cur = hist_q[(head_q + i) % len];
            cnt = 0;
            for (int unsigned j = 0; j <= i; j++)
            begin
                if (hist_q[(head_q + j) % len] == cur)
                    cnt++;
            end
            // strict overtake keeps the earliest label on a tie
            if (cnt > best_cnt && cur != '0)
            begin
                best_cnt = cnt;
                best     = cur;
            end
        end
        return (best_cnt >= min_count_q) ? best : '0;
    endfunction

    // sender gap with noise on the payload
    task automatic idle_input(int n);
        repeat (n)
        begin
            @(negedge clk);
            lin.valid       <= 1'b0;
            lin.class_label <= LBL_W'($urandom);
        end
    endtask

    // offer one beat in bursts, predict it once accepted
    task automatic offer_label(logic [LBL_W-1:0] lbl, logic typed, logic [LBL_W-1:0] fixed);
        logic [LBL_W-1:0] want;
        if (burst_left == 0)
        begin
            if (!steady && $urandom_range(0, 4) != 0)
                idle_input($urandom_range(1, 15));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        lin.valid       <= 1'b1;
        lin.class_label <= lbl;
        do
            @(posedge clk);
        while (!lin.ready);
        want = predict_mode(lbl);
        if (typed)
            want = fixed;
        pending_labels.insert(pending_labels.size(), want);
        labels_sent++;
    endtask

    // wait until every beat is back and the block is idle
    task automatic settle();
        @(negedge clk);
        lin.valid <= 1'b0;
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [SWMF_CFG_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        @(posedge clk);
        predict_config(idx, v);
        cfg_count++;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && lout.valid && lout.ready)
        begin
            if (pending_labels.size() == 0)
            begin
                $error("filtered_label: unexpected beat, got %h", lout.filtered_label);
                error_count++;
            end
            else
            begin
                expected_label = pending_labels.pop_front();
                labels_checked++;
                if (lout.filtered_label !== expected_label)
                begin
                    $error("filtered_label: expected %h, got %h",
                           expected_label, lout.filtered_label);
                    error_count++;
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        lout.ready   = 1'b0;
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_hold_left = 0;
        rx_tick      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && rx_hold_left == 0)
            begin
                rx_hold_left = LONG_HOLD;
                hold_count++;
            end
            if (rx_hold_left > 0)
            begin
                lout.ready <= 1'b0;
                rx_hold_left--;
                if (rx_hold_left == 0)
                    hold_req = 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(50, 400);
                end
                rx_mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:        lout.ready <= 1'b1;
                    RX_MOSTLY:      lout.ready <= ($urandom_range(0, 3) != 0);
                    RX_EVERY_THIRD: lout.ready <= (rx_tick % 3 == 0);
                    default:        lout.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // main sequence
    initial
    begin
        int                    phase_no;
        int                    hold_phase;
        int                    n_items;
        int                    n_alpha;
        int                    eff;
        int                    pick;
        logic [SWMF_CFG_W-1:0] new_len;
        logic [SWMF_CFG_W-1:0] new_min;
        logic [LBL_W-1:0]      alphabet [4];
        logic [LBL_W-1:0]      lbl;

        rst_n           = 1'b0;
        lin.valid       = 1'b0;
        lin.class_label = '0;
        cfg_write_en    = 1'b0;
        cfg_index       = REG_MIN_COUNT;
        cfg_data        = '0;
        hold_req        = 1'b0;
        steady          = 1'b0;
        burst_left      = 0;
        phase_no        = 0;
        wipe_history();
        min_count_q = SWMF_MIN_COUNT_RST;
        win_len_q   = SWMF_WINDOW_LENGTH_RST;

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].reg_idx, dir_rows[r].value[SWMF_CFG_W-1:0]);
            else
                offer_label(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].result);
        end

        // random phases, each with its own settings and label alphabet
        hold_phase = $urandom_range(2, 6);
        while (labels_sent < TARGET_LABELS)
        begin
            phase_no++;

            // mostly short windows, a few full or out-of-range ones
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                new_len = SWMF_CFG_W'($urandom_range(1, 6));
            else if (pick <= 7)
                new_len = SWMF_CFG_W'($urandom_range(7, WIN_MAX - 1));
            else if (pick == 8)
                new_len = SWMF_CFG_W'(WIN_MAX);
            else
                new_len = $urandom_range(0, 1) ? '0 : SWMF_CFG_W'($urandom_range(WIN_MAX + 1, 63));
            eff = (new_len == 0) ? 1 : (new_len > WIN_MAX) ? WIN_MAX : int'(new_len);

            pick = $urandom_range(0, 9);
            if (pick == 0)
                new_min = '0;
            else if (pick == 1)
                new_min = SWMF_CFG_W'($urandom_range(eff + 1, 63));
            else
                new_min = SWMF_CFG_W'($urandom_range(1, eff));

            if ($urandom_range(0, 1))
            begin
                write_reg(REG_WINDOW_LENGTH, new_len);
                write_reg(REG_MIN_COUNT, new_min);
            end
            else
            begin
                write_reg(REG_MIN_COUNT, new_min);
                write_reg(REG_WINDOW_LENGTH, new_len);
            end

            // small alphabet so modes actually form
            n_alpha = $urandom_range(1, 4);
            foreach (alphabet[k])
                alphabet[k] = $urandom_range(0, 1) ? LBL_W'($urandom_range(1, 9))
                                                   : LBL_W'($urandom_range(1, 16'hFFFF));

            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            if (phase_no == hold_phase)
                hold_req = 1'b1;

            n_items = $urandom_range(20, 80);
            repeat (n_items)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    lbl = alphabet[$urandom_range(0, n_alpha - 1)];
                else if (pick < 17)
                    lbl = '0;
                else
                    lbl = LBL_W'($urandom);
                offer_label(lbl, 1'b0, '0);
            end
        end

        // drain and finish
        settle();
        $display("run covered %0d labels in %0d random phases with %0d register writes",
                 labels_sent, phase_no, cfg_count);
        $display("%0d results checked, %0d long receiver hold-offs", labels_checked, hold_count);
        if (error_count == 0)
            $display("sliding_window_label_mode_filter_tb: clean");
        else
            $display("sliding_window_label_mode_filter_tb: errors");
        $finish;
    end

endmodule
